FILE: rtl/crc_framed_request_deframer_macros.svh
// Assertion macros used by the deframer top level.
`ifndef CRC_FRAMED_REQUEST_DEFRAMER_MACROS_SVH
`define CRC_FRAMED_REQUEST_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFRD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CFRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

FILE: rtl/cfrd_pkg.sv
// Shared types, codes and the CRC16-CCITT byte update for the request deframer.
`default_nettype none

package cfrd_pkg;

  // Input operation codes
  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_ABORT = 2'd2;

  // Result kinds
  localparam logic [1:0] EV_PAYLOAD = 2'd0;
  localparam logic [1:0] EV_GOOD    = 2'd1;
  localparam logic [1:0] EV_BAD     = 2'd2;

  // Parser phases
  localparam logic [2:0] PH_WAIT     = 3'd0;
  localparam logic [2:0] PH_COMMAND  = 3'd1;
  localparam logic [2:0] PH_SEQUENCE = 3'd2;
  localparam logic [2:0] PH_LENGTH   = 3'd3;
  localparam logic [2:0] PH_DATA     = 3'd4;
  localparam logic [2:0] PH_CRC_HI   = 3'd5;
  localparam logic [2:0] PH_CRC_LO   = 3'd6;

  // Register indexes (byte address = 4 * index)
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;
  localparam logic [2:0] REG_START_BYTE = 3'd0;
  localparam logic [2:0] REG_GET_CODE   = 3'd1;
  localparam logic [2:0] REG_SET_CODE   = 3'd2;
  localparam logic [2:0] REG_SET_SIZE   = 3'd3;
  localparam logic [2:0] REG_TIMEOUT    = 3'd4;

  // Register reset values
  localparam logic [7:0]  RST_START_BYTE = 8'hA5;
  localparam logic [7:0]  RST_GET_CODE   = 8'h47;
  localparam logic [7:0]  RST_SET_CODE   = 8'h53;
  localparam logic [7:0]  RST_SET_SIZE   = 8'd217;
  localparam logic [15:0] RST_TIMEOUT    = 16'd250;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] IDLE_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] frame_command;
    logic [7:0] frame_sequence;
    logic [7:0] payload_index;
    logic [7:0] payload_value;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  request_start_byte;
    logic [7:0]  get_command_code;
    logic [7:0]  set_command_code;
    logic [7:0]  set_payload_size;
    logic [15:0] frame_timeout_ticks;
  } cfg_t;

  // Advance the CRC by one byte, MSB first, no reflection.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cfrd_cfg_regs.sv
// APB-style configuration register file for the request deframer.
`default_nettype none

module cfrd_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cfrd_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [cfrd_pkg::PDATA_W-1:0]  pwdata,
  output logic      [cfrd_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  output cfrd_pkg::cfg_t                     cfg_o
);

  cfrd_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]     reg_idx;
  logic           wr_en;

  assign reg_idx = paddr[cfrd_pkg::PADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        cfrd_pkg::REG_START_BYTE: cfg_d.request_start_byte  = pwdata[7:0];
        cfrd_pkg::REG_GET_CODE:   cfg_d.get_command_code    = pwdata[7:0];
        cfrd_pkg::REG_SET_CODE:   cfg_d.set_command_code    = pwdata[7:0];
        cfrd_pkg::REG_SET_SIZE:   cfg_d.set_payload_size    = pwdata[7:0];
        cfrd_pkg::REG_TIMEOUT:    cfg_d.frame_timeout_ticks = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cfrd_pkg::REG_START_BYTE: prdata = {24'd0, cfg_q.request_start_byte};
      cfrd_pkg::REG_GET_CODE:   prdata = {24'd0, cfg_q.get_command_code};
      cfrd_pkg::REG_SET_CODE:   prdata = {24'd0, cfg_q.set_command_code};
      cfrd_pkg::REG_SET_SIZE:   prdata = {24'd0, cfg_q.set_payload_size};
      cfrd_pkg::REG_TIMEOUT:    prdata = {16'd0, cfg_q.frame_timeout_ticks};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.request_start_byte  <= cfrd_pkg::RST_START_BYTE;
      cfg_q.get_command_code    <= cfrd_pkg::RST_GET_CODE;
      cfg_q.set_command_code    <= cfrd_pkg::RST_SET_CODE;
      cfg_q.set_payload_size    <= cfrd_pkg::RST_SET_SIZE;
      cfg_q.frame_timeout_ticks <= cfrd_pkg::RST_TIMEOUT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cfrd_parser.sv
// Frame parser state, CRC accumulation and per-transaction result logic.
`default_nettype none

module cfrd_parser (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                fire_i,
  input  wire cfrd_pkg::in_item_t  item_i,
  input  wire cfrd_pkg::cfg_t      cfg_i,
  output logic                     res_valid_o,
  output cfrd_pkg::out_item_t      res_o
);

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  seq_q, seq_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_hi_q, crc_hi_d;
  logic [15:0] idle_q, idle_d;

  logic [15:0] crc_next;
  logic [7:0]  pos_inc;
  logic        clear;
  logic        len_bad;
  logic [7:0]  b;

  assign b        = item_i.rx_byte;
  assign crc_next = cfrd_pkg::crc16_byte(crc_q, b);
  assign pos_inc  = pos_q + 8'd1;

  always_comb begin
    if (cmd_q == cfg_i.get_command_code) begin
      len_bad = (b != 8'd0);
    end else if (cmd_q == cfg_i.set_command_code) begin
      len_bad = (b != cfg_i.set_payload_size);
    end else begin
      len_bad = 1'b0;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    cmd_d    = cmd_q;
    seq_d    = seq_q;
    len_d    = len_q;
    pos_d    = pos_q;
    crc_d    = crc_q;
    crc_hi_d = crc_hi_q;
    idle_d   = idle_q;
    clear    = 1'b0;

    res_valid_o          = 1'b0;
    res_o.event_kind     = cfrd_pkg::EV_PAYLOAD;
    res_o.frame_command  = cmd_q;
    res_o.frame_sequence = seq_q;
    res_o.payload_index  = 8'd0;
    res_o.payload_value  = 8'd0;

    if (fire_i) begin
      case (item_i.op)
        cfrd_pkg::OP_TICK: begin
          if (idle_q != cfrd_pkg::IDLE_MAX) begin
            idle_d = idle_q + 16'd1;
          end
          if (phase_q != cfrd_pkg::PH_WAIT && idle_d >= cfg_i.frame_timeout_ticks) begin
            clear = 1'b1;
          end
        end
        cfrd_pkg::OP_ABORT: begin
          clear = 1'b1;
        end
        cfrd_pkg::OP_BYTE: begin
          idle_d = '0;
          case (phase_q)
            cfrd_pkg::PH_WAIT: begin
              if (b == cfg_i.request_start_byte) begin
                phase_d = cfrd_pkg::PH_COMMAND;
                crc_d   = cfrd_pkg::CRC_INIT;
              end
            end
            cfrd_pkg::PH_COMMAND: begin
              if (b != cfg_i.get_command_code && b != cfg_i.set_command_code) begin
                clear = 1'b1;
              end else begin
                cmd_d   = b;
                crc_d   = crc_next;
                phase_d = cfrd_pkg::PH_SEQUENCE;
              end
            end
            cfrd_pkg::PH_SEQUENCE: begin
              seq_d   = b;
              crc_d   = crc_next;
              phase_d = cfrd_pkg::PH_LENGTH;
            end
            cfrd_pkg::PH_LENGTH: begin
              len_d = b;
              crc_d = crc_next;
              if (len_bad) begin
                res_valid_o      = 1'b1;
                res_o.event_kind = cfrd_pkg::EV_BAD;
                clear            = 1'b1;
              end else begin
                pos_d   = 8'd0;
                phase_d = (b != 8'd0) ? cfrd_pkg::PH_DATA : cfrd_pkg::PH_CRC_HI;
              end
            end
            cfrd_pkg::PH_DATA: begin
              res_valid_o         = 1'b1;
              res_o.event_kind    = cfrd_pkg::EV_PAYLOAD;
              res_o.payload_index = pos_q;
              res_o.payload_value = b;
              crc_d               = crc_next;
              pos_d               = pos_inc;
              if (pos_inc >= len_q) begin
                phase_d = cfrd_pkg::PH_CRC_HI;
              end
            end
            cfrd_pkg::PH_CRC_HI: begin
              crc_hi_d = b;
              phase_d  = cfrd_pkg::PH_CRC_LO;
            end
            cfrd_pkg::PH_CRC_LO: begin
              res_valid_o      = 1'b1;
              res_o.event_kind = ({crc_hi_q, b} == crc_q) ? cfrd_pkg::EV_GOOD
                                                           : cfrd_pkg::EV_BAD;
              clear            = 1'b1;
            end
            default: begin
              clear = 1'b1;
            end
          endcase
        end
        default: ;
      endcase
    end

    // Drop the partial frame; the idle counter keeps running.
    if (clear) begin
      phase_d  = cfrd_pkg::PH_WAIT;
      cmd_d    = '0;
      seq_d    = '0;
      len_d    = '0;
      pos_d    = '0;
      crc_d    = cfrd_pkg::CRC_INIT;
      crc_hi_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= cfrd_pkg::PH_WAIT;
      cmd_q    <= '0;
      seq_q    <= '0;
      len_q    <= '0;
      pos_q    <= '0;
      crc_q    <= cfrd_pkg::CRC_INIT;
      crc_hi_q <= '0;
      idle_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      cmd_q    <= cmd_d;
      seq_q    <= seq_d;
      len_q    <= len_d;
      pos_q    <= pos_d;
      crc_q    <= crc_d;
      crc_hi_q <= crc_hi_d;
      idle_q   <= idle_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/crc_framed_request_deframer.sv
// Top level of the CRC16-framed request deframer: input register, parser, result register.
// Path: an accepted transaction is held in the input register, is parsed as it leaves it,
// and its result, if any, lands in the result register, from which it is offered.
// Throughput: one transaction per cycle; the input register, the parser update and the
// result register all advance together whenever the result register is free or drained.
// Reset: rst_ni clears both pipeline valids, the parser state and the idle tick counter,
// and loads the configuration registers with their default values.
`default_nettype none

`include "crc_framed_request_deframer_macros.svh"

module crc_framed_request_deframer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Input channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire cfrd_pkg::in_item_t            in_data_i,
  // Result channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output cfrd_pkg::out_item_t                out_data_o,
  // Configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cfrd_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [cfrd_pkg::PDATA_W-1:0]  pwdata,
  output logic      [cfrd_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready
);

  cfrd_pkg::cfg_t      cfg;
  cfrd_pkg::in_item_t  in_data_q;
  logic                in_valid_q, in_valid_d;
  cfrd_pkg::out_item_t out_data_q;
  logic                out_valid_q, out_valid_d;
  cfrd_pkg::out_item_t res;
  logic                res_valid;
  logic                advance;
  logic                fire;
  logic                in_accept;

  cfrd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The pipeline moves whenever the result register is empty or being drained.
  assign advance    = !out_valid_q || !out_stall_i;
  // Hold the input register only if it carries a transaction that cannot move.
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  // Process the held transaction as it moves into the result stage.
  assign fire       = in_valid_q && advance;

  cfrd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (in_data_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (!in_stall_o) begin
      in_valid_d = in_valid_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = fire && res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers load only on a transaction; no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_data_q <= in_data_i;
    end
    if (fire && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A full result register that is stalled must hold back a waiting transaction.
  `CFRD_ASSERT_IMPLIES(a_stall_backpressure, clk_i, rst_ni,
                       out_valid_o && out_stall_i && in_valid_q, in_stall_o)
  // With nothing in the input register and the output free to drain, no result appears.
  `CFRD_ASSERT_NEXT(a_no_invented_result, clk_i, rst_ni,
                    !in_valid_q && !(out_valid_o && out_stall_i), !out_valid_o)
  // Only defined result kinds leave the block.
  `CFRD_ASSERT_IMPLIES(a_kind_defined, clk_i, rst_ni, out_valid_o,
                       out_data_o.event_kind == cfrd_pkg::EV_PAYLOAD ||
                       out_data_o.event_kind == cfrd_pkg::EV_GOOD ||
                       out_data_o.event_kind == cfrd_pkg::EV_BAD)

endmodule

`default_nettype wire

FILE: tb/tb_crc_framed_request_deframer.sv
// Self-checking testbench for the CRC16-framed request deframer.
`default_nettype none

module tb_crc_framed_request_deframer;
  import cfrd_pkg::*;

  // Op code that the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int unsigned WHOLE_FRAME        = 1024;  // send every byte of a built frame
  localparam int unsigned DRAIN_CYCLES       = 6;     // margin for the pipeline to empty
  localparam int unsigned HOLD_CYCLES        = 150;   // long receiver hold-off
  localparam int unsigned QUIET_LIMIT        = 1000;  // cycles with no transaction at all
  localparam int unsigned RANDOM_PHASES      = 6;
  localparam int unsigned RANDOM_PHASE_ITEMS = 40;

  typedef logic [7:0] octets_t[$];

  // Clock, reset and block ports
  logic      clk_i      = 1'b0;
  logic      rst_ni     = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i  = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic                 psel    = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite  = 1'b0;
  logic [PADDR_W-1:0]   paddr   = '0;
  logic [PDATA_W-1:0]   pwdata  = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  crc_framed_request_deframer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Stimulus queue, expected results and bookkeeping
  in_item_t    pending_items[$];
  out_item_t   expected_events[$];
  int unsigned items_queued = 0;
  int unsigned items_taken  = 0;
  int unsigned error_count  = 0;

  // Idling controls: set by the stimulus between phases, read by driver and receiver
  bit send_gaps_on   = 1'b1;
  bit recv_stalls_on = 1'b1;
  bit hold_request   = 1'b0;
  bit hold_done      = 1'b0;

  int unsigned send_wait    = 0;
  int unsigned recv_wait    = 0;
  int unsigned hold_left    = 0;
  int unsigned quiet_cycles = 0;

  // Register copy, kept in step with every configuration write
  cfg_t regs;

  // Parser copy used for prediction
  logic [2:0]  frm_phase;
  logic [7:0]  frm_cmd;
  logic [7:0]  frm_seq;
  logic [7:0]  frm_len;
  logic [7:0]  frm_pos;
  logic [15:0] frm_crc;
  logic [7:0]  frm_crc_hi;
  logic [15:0] idle_count;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // CRC16-CCITT, one bit at a time, MSB first, no reflection
  function automatic logic [15:0] crc_ccitt_update(input logic [15:0] acc,
                                                   input logic [7:0] data);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ data[i];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  // Drop any partial frame; the idle tick count survives
  function automatic void drop_frame();
    frm_phase  = PH_WAIT;
    frm_cmd    = '0;
    frm_seq    = '0;
    frm_len    = '0;
    frm_pos    = '0;
    frm_crc    = CRC_INIT;
    frm_crc_hi = '0;
  endfunction

  function automatic void expect_event(input logic [1:0] kind, input logic [7:0] idx,
                                       input logic [7:0] val);
    out_item_t ev;
    ev.event_kind     = kind;
    ev.frame_command  = frm_cmd;
    ev.frame_sequence = frm_seq;
    ev.payload_index  = idx;
    ev.payload_value  = val;
    expected_events.push_back(ev);
  endfunction

  // Advance the parser copy by one accepted transaction
  function automatic void deframe_predict(input in_item_t it);
    logic        length_bad;
    logic [7:0]  b;
    b = it.rx_byte;
    case (it.op)
      OP_TICK: begin
        if (idle_count != IDLE_MAX) begin
          idle_count = idle_count + 16'd1;
        end
        if (frm_phase != PH_WAIT && idle_count >= regs.frame_timeout_ticks) begin
          drop_frame();
        end
      end
      OP_ABORT: begin
        drop_frame();
      end
      OP_BYTE: begin
        idle_count = '0;
        case (frm_phase)
          PH_WAIT: begin
            if (b == regs.request_start_byte) begin
              frm_phase = PH_COMMAND;
              frm_crc   = CRC_INIT;
            end
          end
          PH_COMMAND: begin
            if (b != regs.get_command_code && b != regs.set_command_code) begin
              drop_frame();
            end else begin
              frm_cmd   = b;
              frm_crc   = crc_ccitt_update(frm_crc, b);
              frm_phase = PH_SEQUENCE;
            end
          end
          PH_SEQUENCE: begin
            frm_seq   = b;
            frm_crc   = crc_ccitt_update(frm_crc, b);
            frm_phase = PH_LENGTH;
          end
          PH_LENGTH: begin
            frm_len = b;
            frm_crc = crc_ccitt_update(frm_crc, b);
            // a read wins when both codes match; a stale command passes any length
            if (frm_cmd == regs.get_command_code) begin
              length_bad = (b != 8'd0);
            end else if (frm_cmd == regs.set_command_code) begin
              length_bad = (b != regs.set_payload_size);
            end else begin
              length_bad = 1'b0;
            end
            if (length_bad) begin
              expect_event(EV_BAD, 8'd0, 8'd0);
              drop_frame();
            end else begin
              frm_pos   = '0;
              frm_phase = (b != 8'd0) ? PH_DATA : PH_CRC_HI;
            end
          end
          PH_DATA: begin
            expect_event(EV_PAYLOAD, frm_pos, b);
            frm_crc = crc_ccitt_update(frm_crc, b);
            frm_pos = frm_pos + 8'd1;
            if (frm_pos >= frm_len) begin
              frm_phase = PH_CRC_HI;
            end
          end
          PH_CRC_HI: begin
            frm_crc_hi = b;
            frm_phase  = PH_CRC_LO;
          end
          PH_CRC_LO: begin
            expect_event(({frm_crc_hi, b} == frm_crc) ? EV_GOOD : EV_BAD, 8'd0, 8'd0);
            drop_frame();
          end
          default: begin
            drop_frame();
          end
        endcase
      end
      default: begin
        // unused op: no effect
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  // Print one line per mismatch and count it
  task automatic report_error(input string what);
    error_count++;
    $display("ERROR at %0t: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: launch queued transactions, hold them while stalled,
  // and may insert idle cycles after each accepted one when gaps are on.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : send_side
    bit       taken;
    logic     next_valid;
    in_item_t next_data;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_wait = 0;
    end else begin
      taken      = in_valid_i && !in_stall_o;
      next_valid = in_valid_i;
      next_data  = in_data_i;
      if (taken) begin
        // predict at the accepting edge
        deframe_predict(in_data_i);
        items_taken++;
        next_valid = 1'b0;
        send_wait  = send_gaps_on ? $urandom_range(0, 4) : 0;
      end
      if (!next_valid) begin
        if (send_wait != 0) begin
          send_wait--;
        end else if (pending_items.size() != 0) begin
          next_data  = pending_items.pop_front();
          next_valid = 1'b1;
        end
      end
      // one nonblocking update per signal per edge
      in_valid_i <= next_valid;
      in_data_i  <= next_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: check each accepted transaction against the oldest
  // expectation, then may stall when stalls are on. A hold request
  // from the stimulus stalls for a long stretch so the block backs up.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : recv_side
    out_item_t   want;
    int unsigned w;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_wait = 0;
    end else begin
      w = recv_wait;
      if (out_valid_o && !out_stall_i) begin
        if (expected_events.size() == 0) begin
          report_error($sformatf("result with nothing expected: %h", out_data_o));
        end else begin
          want = expected_events.pop_front();
          if (out_data_o.event_kind !== want.event_kind) begin
            report_error($sformatf("event_kind %h, want %h",
                                   out_data_o.event_kind, want.event_kind));
          end
          if (out_data_o.frame_command !== want.frame_command) begin
            report_error($sformatf("frame_command %h, want %h",
                                   out_data_o.frame_command, want.frame_command));
          end
          if (out_data_o.frame_sequence !== want.frame_sequence) begin
            report_error($sformatf("frame_sequence %h, want %h",
                                   out_data_o.frame_sequence, want.frame_sequence));
          end
          if (out_data_o.payload_index !== want.payload_index) begin
            report_error($sformatf("payload_index %h, want %h",
                                   out_data_o.payload_index, want.payload_index));
          end
          if (out_data_o.payload_value !== want.payload_value) begin
            report_error($sformatf("payload_value %h, want %h",
                                   out_data_o.payload_value, want.payload_value));
          end
        end
        w = recv_stalls_on ? $urandom_range(0, 4) : 0;
      end else if (w != 0) begin
        w--;
      end
      if (hold_request && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end else if (hold_left != 0) begin
        hold_left--;
      end
      recv_wait = w;
      out_stall_i <= (w != 0) || (hold_left != 0);
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_item(input logic [1:0] op, input logic [7:0] b);
    in_item_t it;
    it.op      = op;
    it.rx_byte = b;
    pending_items.push_back(it);
    items_queued++;
  endtask

  function automatic octets_t random_body(input int unsigned n);
    octets_t q;
    repeat (n) q.push_back(8'($urandom));
    return q;
  endfunction

  // Build start, command, sequence, length, body and CRC; send bytes
  // from_idx up to (not including) to_idx. Ticks may be slipped in.
  task automatic queue_frame(input logic [7:0] cmd, input logic [7:0] seq,
                             input logic [7:0] len, input octets_t body,
                             input bit crc_ok, input int unsigned from_idx,
                             input int unsigned to_idx, input int unsigned tick_pct);
    octets_t     frame_bytes;
    logic [15:0] crc;
    frame_bytes.push_back(regs.request_start_byte);
    frame_bytes.push_back(cmd);
    frame_bytes.push_back(seq);
    frame_bytes.push_back(len);
    foreach (body[i]) frame_bytes.push_back(body[i]);
    crc = CRC_INIT;
    for (int i = 1; i < frame_bytes.size(); i++) begin
      crc = crc_ccitt_update(crc, frame_bytes[i]);
    end
    if (!crc_ok) begin
      crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    end
    frame_bytes.push_back(crc[15:8]);
    frame_bytes.push_back(crc[7:0]);
    foreach (frame_bytes[i]) begin
      if (i >= from_idx && i < to_idx) begin
        if ($urandom_range(1, 100) <= tick_pct) begin
          repeat ($urandom_range(1, 3)) queue_item(OP_TICK, 8'($urandom));
        end
        queue_item(OP_BYTE, frame_bytes[i]);
      end
    end
  endtask

  // Wait until every transaction is taken and every result is in,
  // then let the pipeline empty out.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (items_taken != items_queued || expected_events.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_START_BYTE: regs.request_start_byte  = val[7:0];
      REG_GET_CODE:   regs.get_command_code    = val[7:0];
      REG_SET_CODE:   regs.set_command_code    = val[7:0];
      REG_SET_SIZE:   regs.set_payload_size    = val[7:0];
      REG_TIMEOUT:    regs.frame_timeout_ticks = val[15:0];
      default: ;
    endcase
  endtask

  // Drain, rewrite every register, set the idling for the next phase
  task automatic begin_phase(input cfg_t c, input bit gaps, input bit stalls);
    wait_drained();
    apb_write(REG_START_BYTE, 32'(c.request_start_byte));
    apb_write(REG_GET_CODE, 32'(c.get_command_code));
    apb_write(REG_SET_CODE, 32'(c.set_command_code));
    apb_write(REG_SET_SIZE, 32'(c.set_payload_size));
    apb_write(REG_TIMEOUT, 32'(c.frame_timeout_ticks));
    send_gaps_on   = gaps;
    recv_stalls_on = stalls;
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    cfg_t        c;
    octets_t     none;
    octets_t     kept_body;
    logic [7:0]  kept_cmd;
    logic [7:0]  kept_seq;
    logic [7:0]  cmd;
    int unsigned len;
    int unsigned pick;
    int unsigned n;
    int unsigned phase_mark;

    regs.request_start_byte  = RST_START_BYTE;
    regs.get_command_code    = RST_GET_CODE;
    regs.set_command_code    = RST_SET_CODE;
    regs.set_payload_size    = RST_SET_SIZE;
    regs.frame_timeout_ticks = RST_TIMEOUT;
    drop_frame();
    idle_count = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Defaults after reset: noise, good and bad CRC reads, bad lengths,
    // an unknown command, an abort mid-frame, ticks and the unused op.
    @(negedge clk_i);
    queue_item(OP_BYTE, 8'h00);
    queue_item(OP_UNUSED, 8'hFF);
    queue_frame(regs.get_command_code, 8'h00, 8'd0, none, 1'b1, 0, WHOLE_FRAME, 0);
    queue_frame(regs.get_command_code, 8'hFF, 8'd0, none, 1'b0, 0, WHOLE_FRAME, 0);
    queue_frame(regs.get_command_code, 8'h12, 8'd5, none, 1'b1, 0, 4, 0);
    queue_frame(regs.set_command_code, 8'h34, 8'd16, none, 1'b1, 0, 4, 0);
    queue_item(OP_BYTE, regs.request_start_byte);
    queue_item(OP_BYTE, 8'h99);
    queue_frame(regs.set_command_code, 8'h07, regs.set_payload_size, none, 1'b1, 0, 3, 0);
    queue_item(OP_ABORT, 8'h5A);
    queue_item(OP_TICK, 8'hA5);

    // Low extremes: one-byte writes, timeout of one tick
    c = '{request_start_byte: 8'h00, get_command_code: 8'hFF, set_command_code: 8'h00,
          set_payload_size: 8'd1, frame_timeout_ticks: 16'd1};
    begin_phase(c, 1'b0, 1'b1);
    queue_frame(regs.set_command_code, 8'hFF, 8'd1, '{8'hFF}, 1'b1, 0, WHOLE_FRAME, 0);
    queue_frame(regs.set_command_code, 8'h00, 8'd1, '{8'h00}, 1'b1, 0, WHOLE_FRAME, 0);
    queue_frame(regs.get_command_code, 8'h80, 8'd0, none, 1'b1, 0, WHOLE_FRAME, 0);
    queue_frame(regs.set_command_code, 8'h21, 8'd2, none, 1'b1, 0, 4, 0);
    // a single tick drops this partial frame
    queue_frame(regs.get_command_code, 8'h01, 8'd0, none, 1'b1, 0, 3, 0);
    queue_item(OP_TICK, 8'h00);
    queue_item(OP_TICK, 8'hFF);
    // leave a write frame open across the next register change
    kept_cmd  = regs.set_command_code;
    kept_seq  = 8'h5A;
    kept_body = random_body(3);
    queue_frame(kept_cmd, kept_seq, 8'd3, kept_body, 1'b1, 0, 3, 0);

    // High extremes with equal command codes; the open frame's command is now stale
    c = '{request_start_byte: 8'hFF, get_command_code: 8'h3C, set_command_code: 8'h3C,
          set_payload_size: 8'd255, frame_timeout_ticks: 16'hFFFF};
    begin_phase(c, 1'b1, 1'b0);
    queue_frame(kept_cmd, kept_seq, 8'd3, kept_body, 1'b1, 3, WHOLE_FRAME, 0);
    queue_frame(8'h3C, 8'h01, 8'd0, none, 1'b1, 0, WHOLE_FRAME, 0);
    queue_frame(8'h3C, 8'h02, 8'd255, none, 1'b1, 0, 4, 0);

    // Largest payload, no idling on either side
    c = '{request_start_byte: 8'h7E, get_command_code: 8'h10, set_command_code: 8'h20,
          set_payload_size: 8'd255, frame_timeout_ticks: 16'hFFFF};
    begin_phase(c, 1'b0, 1'b0);
    queue_frame(8'h20, 8'hC3, 8'd255, random_body(255), 1'b1, 0, WHOLE_FRAME, 2);

    // Random phases: mostly well-formed frames, the rest broken or noise
    for (int k = 0; k < RANDOM_PHASES; k++) begin
      c.request_start_byte = 8'($urandom);
      c.get_command_code   = 8'($urandom);
      c.set_command_code   = ($urandom_range(0, 7) == 0) ? c.get_command_code : 8'($urandom);
      c.set_payload_size   = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(7, 40))
                                                         : 8'($urandom_range(1, 6));
      c.frame_timeout_ticks = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                                          : 16'($urandom_range(1, 8));
      begin_phase(c, (k % 3) != 0, (k % 2) == 0);
      if (k == 3) begin
        // back the block up: receiver holds off while the sender keeps offering
        hold_request = 1'b1;
      end
      phase_mark = items_queued;
      while (items_queued - phase_mark < RANDOM_PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        cmd  = $urandom_range(0, 1) ? regs.get_command_code : regs.set_command_code;
        len  = (cmd == regs.get_command_code) ? 0 : regs.set_payload_size;
        if (pick < 70) begin
          queue_frame(cmd, 8'($urandom), 8'(len), random_body(len),
                      $urandom_range(0, 6) != 0, 0, WHOLE_FRAME, 4);
        end else if (pick < 78) begin
          // length that cannot fit the command
          if (cmd == regs.get_command_code) begin
            len = $urandom_range(1, 255);
          end else begin
            len = (regs.set_payload_size + $urandom_range(1, 255)) & 8'hFF;
          end
          queue_frame(cmd, 8'($urandom), 8'(len), none, 1'b1, 0, 4, 0);
        end else if (pick < 84) begin
          queue_item(OP_BYTE, regs.request_start_byte);
          queue_item(OP_BYTE, 8'($urandom));
        end else if (pick < 90) begin
          queue_frame(cmd, 8'($urandom), 8'(len), random_body(len), 1'b1, 0,
                      $urandom_range(1, len + 4), 0);
          queue_item(OP_ABORT, 8'($urandom));
        end else if (pick < 95) begin
          // cut the frame short, then tick to or just short of a timeout of at most 8, else 1 to 8 times
          queue_frame(cmd, 8'($urandom), 8'(len), random_body(len), 1'b1, 0,
                      $urandom_range(2, len + 5), 0);
          if (regs.frame_timeout_ticks <= 8) begin
            n = $urandom_range(regs.frame_timeout_ticks - 1, regs.frame_timeout_ticks);
          end else begin
            n = $urandom_range(1, 8);
          end
          repeat (n) queue_item(OP_TICK, 8'($urandom));
        end else begin
          repeat ($urandom_range(1, 4)) queue_item(2'($urandom_range(0, 3)), 8'($urandom));
        end
      end
    end

    wait_drained();
    if (expected_events.size() != 0) begin
      report_error($sformatf("%0d results never arrived", expected_events.size()));
    end
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
